// ===== rtl/core/andcg_pkg.sv =====
// Types, constants and the discount table builder shared by the alpha-nDCG scorer.
package andcg_pkg;

   localparam int TOPICS_DEF    = 16;
   localparam int MAX_DEPTH_DEF = 32;

   localparam int MASK_W     = 16;
   localparam int ALPHA_W    = 16;
   localparam int DEPTH_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int WGT_W      = 17;
   localparam int FRAC_W     = 16;
   localparam int DCG_W      = 24;
   localparam int NDCG_W     = 18;
   localparam int RANK_W     = 5;
   localparam int CNT_W      = 6;
   localparam int DISC_W     = 17;
   localparam int DISC_DEPTH = 2 ** CNT_W;

   localparam logic [WGT_W-1:0]   ONE_Q16     = WGT_W'(65536);
   localparam logic [DCG_W-1:0]   DCG_MAX     = '1;
   localparam logic [NDCG_W-1:0]  NDCG_MAX    = '1;
   localparam logic [ALPHA_W-1:0] ALPHA_RST   = 16'h8000;
   localparam logic [MASK_W-1:0]  QTOPICS_RST = 16'hFFFF;
   localparam logic [DEPTH_W-1:0] DEPTH_RST   = 6'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA        = 2'd0,
      CSR_QUERY_TOPICS = 2'd1,
      CSR_DEPTH_LIMIT  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_GAIN_T,
      ST_GAIN_I,
      ST_SUM_I,
      ST_DIV_GO,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [MASK_W-1:0] target_topics;
      logic [MASK_W-1:0] ideal_topics;
      logic              end_of_ranking;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [DCG_W-1:0]  target_dcg;
      logic [DCG_W-1:0]  ideal_dcg;
      logic [NDCG_W-1:0] ndcg;
      logic              final_res;
   } rsp_type;

   typedef logic [DISC_W-1:0] disc_rom_type [DISC_DEPTH];

   // 1/log2(n) in Q1.16; log2 in Q8.24 by repeated squaring, then rounded reciprocal
   function automatic logic [DISC_W-1:0] disc_value(input int unsigned n);
      logic [63:0] y;
      logic [63:0] len;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [23:0] frac;
      int unsigned k;
      k = 0;
      for (int j = 0; j < 31; j++) begin
         if ((n >> (j + 1)) != 0) k = j + 1;
      end
      y = 64'(n) << (30 - k);
      frac = '0;
      for (int b = 0; b < 24; b++) begin
         y = (y * y) >> 30;
         frac = {frac[22:0], 1'b0};
         if (y >= 64'h8000_0000) begin
            frac[0] = 1'b1;
            y = y >> 1;
         end
      end
      len = (64'(k) << 24) | 64'(frac);
      num = (64'd1 << 40) + (len >> 1);
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= len) begin
            rem = rem - len;
            quo[i] = 1'b1;
         end
      end
      return quo[DISC_W-1:0];
   endfunction

   function automatic disc_rom_type build_disc_rom();
      disc_rom_type rom;
      for (int r = 0; r < DISC_DEPTH; r++) begin
         rom[r] = disc_value(r + 2);
      end
      return rom;
   endfunction

endpackage

// ===== rtl/core/alpha_ndcg_scorer_top.sv =====
// alpha-nDCG scorer: takes one rank position per transaction and returns the running target
// and ideal alpha-DCG with their Q2.16 ratio. To score a position, with TOPICS capped at 16,
// every topic weight of both rankings passes one at a time through the single shared
// multiplier, two more passes scale the weight sums by the discount, and the radix-2 divider
// forms the ratio. When the target DCG is zero or the ratio saturates the divider answers
// without iterating. A position past the depth limit gives no result. The input is not ready
// while a position is being scored; a finished result waits in the output register and does
// not hold up the next transaction, but the one after that stalls until the register is taken.
module alpha_ndcg_scorer_top #(
   parameter int TOPICS    = andcg_pkg::TOPICS_DEF,
   parameter int MAX_DEPTH = andcg_pkg::MAX_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  andcg_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output andcg_pkg::rsp_type               rsp_data,
   input  logic                             csr_wen,
   input  logic [andcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [andcg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import andcg_pkg::*;

   localparam int TN     = (TOPICS < MASK_W) ? TOPICS : MASK_W;
   localparam int IDX_W  = (TN > 1) ? $clog2(TN) : 1;
   localparam int STEP_W = IDX_W + 1;
   localparam int TOT_W  = WGT_W + $clog2(TN + 1);
   localparam int PROD_W = TOT_W + WGT_W;
   localparam int GAIN_W = PROD_W - FRAC_W + 1;
   localparam int ACC_W  = ((GAIN_W > DCG_W) ? GAIN_W : DCG_W) + 1;
   localparam int LIM_W  = ($clog2(MAX_DEPTH + 1) > CNT_W) ? $clog2(MAX_DEPTH + 1) : CNT_W;
   localparam disc_rom_type DISC_ROM = build_disc_rom();
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);

   state_type            state_ff, state_in;
   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [MASK_W-1:0]    qtopics_ff, qtopics_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [CNT_W-1:0]     rank_cnt_ff, rank_cnt_in;
   logic [DCG_W-1:0]     tsum_ff, tsum_in;
   logic [DCG_W-1:0]     isum_ff, isum_in;
   logic [TN-1:0]        tmask_ff, tmask_in;
   logic [TN-1:0]        imask_ff, imask_in;
   logic                 last_ff, last_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TOT_W-1:0]     ttot_ff, ttot_in;
   logic [TOT_W-1:0]     itot_ff, itot_in;
   logic                 wb_valid_ff, wb_valid_in;
   logic                 wb_side_ff, wb_side_in;
   logic [IDX_W-1:0]     wb_idx_ff, wb_idx_in;
   logic                 wb_hit_ff, wb_hit_in;
   logic [TN-1:0]        wv_t_ff, wv_t_in;
   logic [TN-1:0]        wv_i_ff, wv_i_in;
   logic [WGT_W-1:0]     wt_t_ff [TN];
   logic [WGT_W-1:0]     wt_i_ff [TN];
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 in_range;
   logic                 clear;
   logic [IDX_W-1:0]     idx;
   logic                 side;
   logic                 hit;
   logic [WGT_W-1:0]     wgt_rd;
   logic [WGT_W-1:0]     factor;
   logic [DISC_W-1:0]    disc;
   logic                 mul_en;
   logic [TOT_W-1:0]     mul_a;
   logic [WGT_W-1:0]     mul_b;
   logic [PROD_W-1:0]    prod;
   logic [PROD_W:0]      rnd;
   logic [GAIN_W-1:0]    gain;
   logic [WGT_W-1:0]     wb_weight;
   logic                 div_start;
   logic                 div_done;
   logic [NDCG_W-1:0]    quotient;

   function automatic logic [DCG_W-1:0] sat_add(input logic [DCG_W-1:0] base,
                                                input logic [GAIN_W-1:0] inc);
      logic [ACC_W-1:0] acc;
      acc = ACC_W'(base) + ACC_W'(inc);
      return (acc > ACC_W'(DCG_MAX)) ? DCG_MAX : acc[DCG_W-1:0];
   endfunction

   andcg_mul #(
      .A_W (TOT_W),
      .B_W (WGT_W)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   andcg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tsum_ff),
      .divisor  (isum_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // effective limit is min(depth_limit, MAX_DEPTH)
   assign in_range = (rank_cnt_ff < depth_ff) && (LIM_W'(rank_cnt_ff) < LIM_W'(MAX_DEPTH));

   assign idx    = step_ff[STEP_W-1:1];
   assign side   = step_ff[0];
   assign hit    = side ? imask_ff[idx] : tmask_ff[idx];
   // a weight not yet written this ranking reads as 1.0
   assign wgt_rd = side ? (wv_i_ff[idx] ? wt_i_ff[idx] : ONE_Q16)
                        : (wv_t_ff[idx] ? wt_t_ff[idx] : ONE_Q16);
   assign factor = ONE_Q16 - WGT_W'(alpha_ff);
   assign disc   = DISC_ROM[rank_cnt_ff];

   assign rnd       = {1'b0, prod} + ROUND_HALF;
   assign gain      = rnd[PROD_W:FRAC_W];
   assign wb_weight = prod[WGT_W+FRAC_W-1:FRAC_W];

   always_comb begin
      alpha_in   = alpha_ff;
      qtopics_in = qtopics_ff;
      depth_in   = depth_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_ALPHA:        alpha_in   = csr_wdata[ALPHA_W-1:0];
            CSR_QUERY_TOPICS: qtopics_in = csr_wdata[MASK_W-1:0];
            CSR_DEPTH_LIMIT:  depth_in   = csr_wdata[DEPTH_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rank_cnt_in  = rank_cnt_ff;
      tsum_in      = tsum_ff;
      isum_in      = isum_ff;
      tmask_in     = tmask_ff;
      imask_in     = imask_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      ttot_in      = ttot_ff;
      itot_in      = itot_ff;
      wb_valid_in  = 1'b0;
      wb_side_in   = wb_side_ff;
      wb_idx_in    = wb_idx_ff;
      wb_hit_in    = wb_hit_ff;
      wv_t_in      = wv_t_ff;
      wv_i_in      = wv_i_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      clear        = 1'b0;

      if (wb_valid_ff && wb_hit_ff) begin
         if (wb_side_ff) wv_i_in[wb_idx_ff] = 1'b1;
         else            wv_t_in[wb_idx_ff] = 1'b1;
      end
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               tmask_in = req_data.target_topics[TN-1:0] & qtopics_ff[TN-1:0];
               imask_in = req_data.ideal_topics[TN-1:0] & qtopics_ff[TN-1:0];
               last_in  = req_data.end_of_ranking;
               step_in  = '0;
               ttot_in  = '0;
               itot_in  = '0;
               if (in_range) state_in = ST_WEIGHT;
               else if (req_data.end_of_ranking) clear = 1'b1;
            end
         end
         ST_WEIGHT: begin
            // even steps: target weight, odd steps: ideal weight of the same topic
            mul_en      = 1'b1;
            mul_a       = TOT_W'(wgt_rd);
            mul_b       = factor;
            wb_valid_in = 1'b1;
            wb_side_in  = side;
            wb_idx_in   = idx;
            wb_hit_in   = hit;
            if (hit) begin
               if (side) itot_in = itot_ff + TOT_W'(wgt_rd);
               else      ttot_in = ttot_ff + TOT_W'(wgt_rd);
            end
            if (step_ff == STEP_W'(2 * TN - 1)) state_in = ST_GAIN_T;
            else                                 step_in  = step_ff + 1'b1;
         end
         ST_GAIN_T: begin
            mul_en   = 1'b1;
            mul_a    = ttot_ff;
            mul_b    = WGT_W'(disc);
            state_in = ST_GAIN_I;
         end
         ST_GAIN_I: begin
            mul_en   = 1'b1;
            mul_a    = itot_ff;
            mul_b    = WGT_W'(disc);
            tsum_in  = sat_add(tsum_ff, gain);
            state_in = ST_SUM_I;
         end
         ST_SUM_I: begin
            isum_in  = sat_add(isum_ff, gain);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.rank       = rank_cnt_ff[RANK_W-1:0];
               rsp_in.target_dcg = tsum_ff;
               rsp_in.ideal_dcg  = isum_ff;
               rsp_in.ndcg       = quotient;
               rsp_in.final_res  = last_ff;
               rank_cnt_in      = rank_cnt_ff + 1'b1;
               if (last_ff) clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (clear) begin
         rank_cnt_in = '0;
         tsum_in     = '0;
         isum_in     = '0;
         wv_t_in     = '0;
         wv_i_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RST;
         qtopics_ff   <= QTOPICS_RST;
         depth_ff     <= DEPTH_RST;
         rank_cnt_ff  <= '0;
         tsum_ff      <= '0;
         isum_ff      <= '0;
         wb_valid_ff  <= 1'b0;
         wv_t_ff      <= '0;
         wv_i_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         qtopics_ff   <= qtopics_in;
         depth_ff     <= depth_in;
         rank_cnt_ff  <= rank_cnt_in;
         tsum_ff      <= tsum_in;
         isum_ff      <= isum_in;
         wb_valid_ff  <= wb_valid_in;
         wv_t_ff      <= wv_t_in;
         wv_i_ff      <= wv_i_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmask_ff   <= tmask_in;
      imask_ff   <= imask_in;
      last_ff    <= last_in;
      step_ff    <= step_in;
      ttot_ff    <= ttot_in;
      itot_ff    <= itot_in;
      wb_side_ff <= wb_side_in;
      wb_idx_ff  <= wb_idx_in;
      wb_hit_ff  <= wb_hit_in;
      rsp_ff     <= rsp_in;
   end

   // weight write-back in the cycle after the multiply
   always_ff @(posedge clock) begin
      if (wb_valid_ff && wb_hit_ff) begin
         if (wb_side_ff) wt_i_ff[wb_idx_ff] <= wb_weight;
         else            wt_t_ff[wb_idx_ff] <= wb_weight;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_wb_window: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == ST_WEIGHT || state_ff == ST_GAIN_T))
      else $error("weight write-back outside the weight pass");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished while not awaited");

   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_OUT)
      else $error("result left before output register was free");

   a_zero_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.target_dcg == '0) |-> rsp_ff.ndcg == '0)
      else $error("nonzero ratio with zero target DCG");

endmodule

// ===== rtl/core/andcg_mul.sv =====
// Shared unsigned multiplier with registered product.
module andcg_mul #(
   parameter int A_W = andcg_pkg::WGT_W + 5,
   parameter int B_W = andcg_pkg::WGT_W
) (
   input  logic               clock,
   input  logic               en,
   input  logic [A_W-1:0]     mul_a,
   input  logic [B_W-1:0]     mul_b,
   output logic [A_W+B_W-1:0] prod
);

   logic [A_W+B_W-1:0] prod_ff;
   logic [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W + B_W)'(mul_a) * (A_W + B_W)'(mul_b);

   always_ff @(posedge clock) begin
      if (en) prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/andcg_div.sv =====
// Radix-2 restoring divider for the saturating Q2.16 target/ideal ratio.
module andcg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [andcg_pkg::DCG_W-1:0] dividend,
   input  logic [andcg_pkg::DCG_W-1:0] divisor,
   output logic                        done,
   output logic [andcg_pkg::NDCG_W-1:0] quotient
);
   import andcg_pkg::*;

   localparam int PRE    = NDCG_W - FRAC_W;
   localparam int ITER_W = $clog2(NDCG_W);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic [DCG_W-1:0]         rem_ff, rem_in;
   logic [DCG_W-1:0]         den_ff, den_in;
   logic [NDCG_W-1:0]        low_ff, low_in;
   logic [NDCG_W-1:0]        quo_ff, quo_in;
   logic [DCG_W:0]           trial;
   logic [DCG_W:0]           diff;
   logic [DCG_W+FRAC_W-1:0]  num_full;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      iter_in  = iter_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      num_full = {dividend, {FRAC_W{1'b0}}};
      trial    = {rem_ff, low_ff[NDCG_W-1]};
      diff     = trial - {1'b0, den_ff};
      if (start) begin
         den_in  = divisor;
         iter_in = '0;
         rem_in  = dividend >> PRE;
         low_in  = num_full[NDCG_W-1:0];
         quo_in  = '0;
         priority if (dividend == '0) begin
            done_in = 1'b1;
         end else if ({{PRE{1'b0}}, dividend} >= {divisor, {PRE{1'b0}}}) begin
            // ratio at or above 4.0, also catches a zero divisor
            quo_in  = NDCG_MAX;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         low_in  = {low_ff[NDCG_W-2:0], 1'b0};
         iter_in = iter_ff + 1'b1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DCG_W-1:0];
            quo_in = {quo_ff[NDCG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DCG_W-1:0];
            quo_in = {quo_ff[NDCG_W-2:0], 1'b0};
         end
         if (iter_ff == ITER_W'(NDCG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== tb/sv/andcg_score_checker.sv =====
// Checker for the alpha-nDCG scorer: tracks register writes, predicts each scored rank, compares.
`timescale 1ns / 100ps
module andcg_score_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  andcg_pkg::req_type               req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  andcg_pkg::rsp_type               rsp_data,
   input  logic                             csr_wen,
   input  logic [andcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [andcg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               mismatches,
   output int                               pending,
   output int                               results_seen
);
   import andcg_pkg::*;

   localparam int SIDES = 2;   // 0: target ranking, 1: ideal ranking

   logic [ALPHA_W-1:0] cur_alpha;
   logic [MASK_W-1:0]  cur_query;
   logic [DEPTH_W-1:0] cur_depth;

   logic [CNT_W-1:0]   rank_pos;
   logic [WGT_W-1:0]   topic_weight [SIDES][TOPICS_DEF];
   logic [DCG_W-1:0]   run_dcg [SIDES];
   logic [DISC_W-1:0]  rank_discount [MAX_DEPTH_DEF];
   rsp_type            expected_scores [$];

   // 1/log2(n) in Q1.16: log2 in Q8.24, fraction bits by repeated squaring
   function automatic logic [DISC_W-1:0] log_discount(input int unsigned n);
      int unsigned ip;
      logic [63:0] sq;
      logic [63:0] frac;
      logic [63:0] log_q24;
      ip = 0;
      while (ip < 31 && (n >> (ip + 1)) != 0) ip++;
      sq = 64'(n) << (30 - ip);
      frac = '0;
      for (int b = 0; b < 24; b++) begin
         sq = (sq * sq) >> 30;
         frac = frac << 1;
         if (sq >= 64'h8000_0000) begin
            frac = frac | 64'd1;
            sq = sq >> 1;
         end
      end
      log_q24 = (64'(ip) << 24) | frac;
      return DISC_W'(((64'd1 << 40) + (log_q24 >> 1)) / log_q24);
   endfunction

   initial begin
      for (int r = 0; r < MAX_DEPTH_DEF; r++) rank_discount[r] = log_discount(r + 2);
   end

   task automatic clear_ranking();
      rank_pos = '0;
      for (int s = 0; s < SIDES; s++) begin
         run_dcg[s] = '0;
         for (int t = 0; t < TOPICS_DEF; t++) topic_weight[s][t] = ONE_Q16;
      end
   endtask

   // sum of hit weights (pre-update) times discount; hit weights decay by the factor
   function automatic logic [63:0] weigh_hits(input int side, input logic [MASK_W-1:0] hits,
                                              input logic [WGT_W-1:0] factor,
                                              input logic [DISC_W-1:0] disc);
      logic [63:0] total;
      total = '0;
      for (int t = 0; t < TOPICS_DEF; t++) begin
         if (hits[t]) begin
            total = total + 64'(topic_weight[side][t]);
            topic_weight[side][t] = WGT_W'((64'(topic_weight[side][t]) * 64'(factor)) >> 16);
         end
      end
      return (total * 64'(disc) + 64'd32768) >> 16;
   endfunction

   function automatic logic [DCG_W-1:0] add_saturated(input logic [DCG_W-1:0] acc,
                                                      input logic [63:0] gain);
      logic [63:0] s;
      s = 64'(acc) + gain;
      return (s > 64'(DCG_MAX)) ? DCG_MAX : s[DCG_W-1:0];
   endfunction

   task automatic predict_position(input req_type item);
      logic [MASK_W-1:0] hits [SIDES];
      logic [CNT_W-1:0]  limit;
      logic [WGT_W-1:0]  factor;
      logic [63:0]       ratio;
      rsp_type           want;
      hits[0] = item.target_topics & cur_query;
      hits[1] = item.ideal_topics & cur_query;
      limit = (cur_depth > MAX_DEPTH_DEF) ? CNT_W'(MAX_DEPTH_DEF) : cur_depth;
      factor = ONE_Q16 - WGT_W'(cur_alpha);
      if (rank_pos < limit) begin
         for (int s = 0; s < SIDES; s++) begin
            run_dcg[s] = add_saturated(run_dcg[s],
                                       weigh_hits(s, hits[s], factor, rank_discount[rank_pos]));
         end
         if (run_dcg[0] == '0) ratio = '0;
         else if (run_dcg[1] == '0) ratio = 64'(NDCG_MAX);
         else begin
            ratio = (64'(run_dcg[0]) << 16) / 64'(run_dcg[1]);
            if (ratio > 64'(NDCG_MAX)) ratio = 64'(NDCG_MAX);
         end
         want.rank       = rank_pos[RANK_W-1:0];
         want.target_dcg = run_dcg[0];
         want.ideal_dcg  = run_dcg[1];
         want.ndcg       = ratio[NDCG_W-1:0];
         want.final_res  = item.end_of_ranking;
         expected_scores.insert(expected_scores.size(), want);
         rank_pos = rank_pos + 1'b1;
      end
      if (item.end_of_ranking) clear_ranking();
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch, %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [RANK_W-1:0] rank,
                              input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         report_mismatch($sformatf("%s at rank %0d: expected %0d, got %0d",
                                   name, rank, want, got));
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (expected_scores.size() == 0) begin
         report_mismatch($sformatf("result for rank %0d with none outstanding", got.rank));
         return;
      end
      want = expected_scores.pop_front();
      check_field("rank", want.rank, 32'(want.rank), 32'(got.rank));
      check_field("target_dcg", want.rank, 32'(want.target_dcg), 32'(got.target_dcg));
      check_field("ideal_dcg", want.rank, 32'(want.ideal_dcg), 32'(got.ideal_dcg));
      check_field("ndcg", want.rank, 32'(want.ndcg), 32'(got.ndcg));
      check_field("final_res", want.rank, 32'(want.final_res), 32'(got.final_res));
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      case (csr_index_type'(index))
         CSR_ALPHA:        cur_alpha = data[ALPHA_W-1:0];
         CSR_QUERY_TOPICS: cur_query = data[MASK_W-1:0];
         CSR_DEPTH_LIMIT:  cur_depth = data[DEPTH_W-1:0];
         default: ;
      endcase
   endtask

   // result checked before the new transaction: a result never belongs to this cycle's input
   always @(posedge clock) begin
      if (reset) begin
         cur_alpha = ALPHA_RST;
         cur_query = QTOPICS_RST;
         cur_depth = DEPTH_RST;
         clear_ranking();
         expected_scores.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) predict_position(req_data);
         if (csr_wen) write_register(csr_index, csr_wdata);
      end
      pending = expected_scores.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the alpha-nDCG scorer: clock, reset, register writes, traffic and verdict.
`timescale 1ns / 100ps
module tb_top;
   import andcg_pkg::*;

   typedef struct {
      logic [ALPHA_W-1:0] alpha;
      logic [MASK_W-1:0]  topics;
      logic [DEPTH_W-1:0] depth;
      int                 quota;
   } score_setting_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wen   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches;
   int pending;
   int results_seen;

   int tx_gap_pct     = 0;
   int rx_stall_pct   = 0;
   int positions_sent = 0;
   int settings_used  = 0;

   score_setting_type plan [9];

   always #2 clock = ~clock;

   alpha_ndcg_scorer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   andcg_score_checker score_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .pending      (pending),
      .results_seen (results_seen)
   );

   // result side: random stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_position(input logic [MASK_W-1:0] target, input logic [MASK_W-1:0] ideal,
                                input logic closes, input int gap_pct);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{target_topics: target, ideal_topics: ideal, end_of_ranking: closes};
      do @(posedge clock); while (!req_ready);
      positions_sent++;
      @(negedge clock);
   endtask

   // drop valid and hold off until every outstanding result is back
   task automatic hold_until_empty();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // extra settle so a position past the depth limit is out of the block before a write
   task automatic wait_drained();
      hold_until_empty();
      repeat (64) @(negedge clock);
   endtask

   task automatic apply_settings(input score_setting_type cfg);
      csr_wen   <= 1'b1;
      csr_index <= CSR_ALPHA;
      csr_wdata <= CSR_DATA_W'(cfg.alpha);
      @(negedge clock);
      csr_index <= CSR_QUERY_TOPICS;
      csr_wdata <= CSR_DATA_W'(cfg.topics);
      @(negedge clock);
      csr_index <= CSR_DEPTH_LIMIT;
      csr_wdata <= CSR_DATA_W'(cfg.depth);
      @(negedge clock);
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [MASK_W-1:0] pick_mask();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
         3, 4:    return MASK_W'($urandom & $urandom & $urandom);
         default: return MASK_W'($urandom);
      endcase
   endfunction

   task automatic run_phase(input score_setting_type cfg);
      int limit;
      int span;
      int gap;
      int scored;
      bit paused;
      scored = 0;
      paused = 1'b0;
      apply_settings(cfg);
      limit = (cfg.depth > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : cfg.depth;
      while (scored < cfg.quota) begin
         // mostly complete rankings; some run past the depth limit
         if ($urandom_range(0, 99) < 85) span = $urandom_range(1, limit);
         else span = $urandom_range(limit + 1, limit + 4);
         gap = ($urandom_range(0, 4) == 0) ? 0 : tx_gap_pct;
         for (int pos = 0; pos < span; pos++) begin
            send_position(pick_mask(), pick_mask(), pos == span - 1, gap);
            if (pos < limit) scored++;
         end
         if (!paused) begin
            hold_until_empty();
            paused = 1'b1;
         end
      end
      wait_drained();
   endtask

   initial begin
      plan[0] = '{16'h8000, 16'hFFFF, 6'd20, 115};
      plan[1] = '{16'h0000, 16'h00FF, 6'd32, 115};
      plan[2] = '{16'hFFFF, 16'hFFFF, 6'd1,  105};
      plan[3] = '{16'($urandom), 16'h0000, 6'd7, 90};
      plan[4] = '{16'h1000, 16'($urandom), 6'd32, 115};
      plan[5] = '{16'hF000, 16'hFFFF, 6'd12, 105};
      plan[6] = '{16'($urandom), 16'hFFFF, 6'd32, 115};
      plan[7] = '{16'h0001, 16'hA5A5, 6'd5,  105};
      plan[8] = '{16'($urandom), 16'($urandom), 6'($urandom_range(1, 32)), 115};

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty target, empty ideal, large ratio, nothing hit, decay
      send_position(16'h0000, 16'hFFFF, 1'b0, 0);
      send_position(16'hFFFF, 16'h0000, 1'b1, 0);
      send_position(16'hFFFF, 16'h0000, 1'b1, 0);
      send_position(16'hFFFF, 16'h0001, 1'b0, 0);
      send_position(16'h0000, 16'h0000, 1'b1, 0);
      send_position(16'h0000, 16'h0000, 1'b1, 0);
      send_position(16'hAAAA, 16'h5555, 1'b0, 0);
      send_position(16'h5555, 16'hAAAA, 1'b0, 0);
      send_position(16'hAAAA, 16'hAAAA, 1'b0, 0);
      send_position(16'h8001, 16'h7FFE, 1'b1, 0);
      wait_drained();

      // past the depth limit: no result; the end flag there still clears the ranking
      apply_settings('{16'h8000, 16'hFFFF, 6'd2, 0});
      send_position(16'hFFFF, 16'hFFFF, 1'b0, 0);
      send_position(16'hFFFF, 16'hFFFF, 1'b0, 0);
      send_position(16'hFFFF, 16'hFFFF, 1'b0, 0);
      send_position(16'hFFFF, 16'hFFFF, 1'b1, 0);
      send_position(16'h0001, 16'h0001, 1'b1, 0);
      wait_drained();

      for (int p = 0; p < 9; p++) begin
         if (p < 3) begin
            tx_gap_pct = 15;
            rx_stall_pct = 88;
         end else if (p < 6) begin
            tx_gap_pct = 88;
            rx_stall_pct = 15;
         end else begin
            tx_gap_pct = 0;
            rx_stall_pct = 0;
         end
         run_phase(plan[p]);
      end

      $display("checked %0d scored positions of %0d sent over %0d register settings",
               results_seen, positions_sent, settings_used);
      $display("alpha, query mask and depth at both ends, slow sender and slow receiver");
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("timed out waiting on a handshake");
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== alpha_ndcg_scorer_top.f =====
rtl/core/andcg_pkg.sv
rtl/core/andcg_mul.sv
rtl/core/andcg_div.sv
rtl/core/alpha_ndcg_scorer_top.sv
tb/sv/andcg_score_checker.sv
tb/sv/tb_top.sv
